[sv/iiel_pkg.sv]
// ----------------------------------------------------------------------------
// iiel_pkg
// Shared types and constants for the indexed insert/erase list.
// ----------------------------------------------------------------------------
`default_nettype none

package iiel_pkg;

	localparam int DEPTH        = 16;
	localparam int ELEMENT_BITS = 32;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int CNT_W        = 5;
	localparam int POS_W        = 5;
	localparam int PORT_ELEM_W  = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef logic [ELEMENT_BITS-1:0] elem_t;

	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_ERASE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_UP   = 2'd2,
		CELL_DOWN = 2'd3
	} cell_op_t;

	// broadcast to every cell each cycle
	typedef struct packed {
		logic             ok;
		action_t          op;
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] count;
	} iiel_ctl_t;

endpackage

`default_nettype wire

[sv/indexed_insert_erase_list.sv]
// ----------------------------------------------------------------------------
// indexed_insert_erase_list
// Bounded ordered list with push, pop, insert-before and erase-at, held in a
// row of cells that shift in parallel.
// ----------------------------------------------------------------------------
//  channel   handshake                beat
//  command   start, busy              action, position, element_in
//  result    done (strobe)            status, element_out, count_after
//  config    cfg_valid, cfg_ready     cfg_data (capacity limit)
//
//  One command per cycle; busy is never raised. The result appears in the cycle
//  after the command, when the cell row and the output register update together.
//  Reset clears the count and restores the capacity limit to 16; entry
//  contents are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_erase_list import iiel_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             action,
	input  wire logic [POS_W-1:0]       position,
	input  wire logic [PORT_ELEM_W-1:0] element_in,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [PORT_ELEM_W-1:0]      element_out,
	output logic [CNT_W-1:0]            count_after,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CNT_W-1:0]       cfg_data
);

	logic             accept;
	logic [CNT_W-1:0] cap_limit_q;
	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	action_t          op;
	status_t          st;
	iiel_ctl_t        ctl;
	elem_t            elem;
	elem_t            cell_data [DEPTH];
	elem_t            pop_data;
	logic [IDX_W-1:0] last_idx;

	logic                   done_q;
	status_t                status_q;
	logic [PORT_ELEM_W-1:0] element_out_q;
	logic [CNT_W-1:0]       count_after_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign op        = action_t'(action);
	assign elem      = ELEMENT_BITS'(element_in);
	assign cap       = (cap_limit_q > DEPTH_CNT) ? DEPTH_CNT : cap_limit_q;

	always_comb begin
		st        = ST_OK;
		count_nxt = count_q;
		unique case (op)
			ACT_PUSH: begin
				if (count_q >= cap) st = ST_FULL;
				else count_nxt = CNT_W'(count_q + CNT_W'(1));
			end
			ACT_POP: begin
				if (count_q == '0) st = ST_EMPTY;
				else count_nxt = CNT_W'(count_q - CNT_W'(1));
			end
			ACT_INSERT: begin
				if (position > count_q) st = ST_RANGE;
				else if (count_q >= cap) st = ST_FULL;
				else count_nxt = CNT_W'(count_q + CNT_W'(1));
			end
			ACT_ERASE: begin
				if (count_q == '0) st = ST_EMPTY;
				else if (position >= count_q) st = ST_RANGE;
				else count_nxt = CNT_W'(count_q - CNT_W'(1));
			end
			default: st = ST_OK;
		endcase
	end

	assign ctl.ok    = accept && (st == ST_OK);
	assign ctl.op    = op;
	assign ctl.pos   = position;
	assign ctl.count = count_q;

	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign pop_data = cell_data[last_idx];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		elem_t lower, upper;
		if (g == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = cell_data[g+1];
		end
		iiel_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(g)),
			.ctl        (ctl),
			.elem_in    (elem),
			.lower_data (lower),
			.upper_data (upper),
			.data       (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_limit_q <= CAP_RESET;
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) cap_limit_q <= cfg_data;
			if (accept) count_q <= count_nxt;
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= st;
			count_after_q <= count_nxt;
			element_out_q <= (op == ACT_POP && st == ST_OK) ?
				PORT_ELEM_W'(pop_data) : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign element_out = element_out_q;
	assign count_after = count_after_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count beyond depth");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> count_after == count_q)
		else $error("reported count differs from stored count");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> count_q == $past(count_q))
		else $error("count moved without a command");

	a_refused_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && st != ST_OK |=> count_q == $past(count_q))
		else $error("refused command changed the count");

	a_pop_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && element_out != '0 |-> status == ST_OK)
		else $error("element returned by a refused command");

endmodule

`default_nettype wire

[sv/iiel_cell.sv]
// ----------------------------------------------------------------------------
// iiel_cell
// One list entry. Decodes the broadcast operation against its own index and
// loads the new element, takes its lower or upper neighbour, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module iiel_cell import iiel_pkg::*; (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] idx,
	input  wire iiel_ctl_t        ctl,
	input  wire elem_t            elem_in,
	input  wire elem_t            lower_data,
	input  wire elem_t            upper_data,
	output elem_t                 data
);

	elem_t            data_q;
	cell_op_t         cmd;
	logic [CNT_W-1:0] ix;
	logic [CNT_W-1:0] ix_next;

	assign ix      = CNT_W'(idx);
	assign ix_next = CNT_W'(ix + CNT_W'(1));

	always_comb begin
		cmd = CELL_HOLD;
		if (ctl.ok) begin
			unique case (ctl.op)
				ACT_PUSH: begin
					if (ix == ctl.count) cmd = CELL_LOAD;
				end
				ACT_INSERT: begin
					if (ix == ctl.pos)
						cmd = CELL_LOAD;
					else if (ix > ctl.pos && ix <= ctl.count)
						cmd = CELL_UP;
				end
				ACT_ERASE: begin
					if (ix >= ctl.pos && ix_next < ctl.count) cmd = CELL_DOWN;
				end
				ACT_POP: begin
					cmd = CELL_HOLD;
				end
				default: cmd = CELL_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_LOAD: data_q <= elem_in;
			CELL_UP:   data_q <= lower_data;
			CELL_DOWN: data_q <= upper_data;
			CELL_HOLD: data_q <= data_q;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire
